// ===== sv/sxf_pkg.sv =====
// Shared types and constants for the sprite XOR framebuffer.
package sxf_pkg;

  localparam int ByteW       = 8;
  localparam int ScreenBytes = 256;
  localparam int AddrW       = $clog2(ScreenBytes);
  localparam int CmdDepth    = 2;

  localparam logic [3:0] MaxSpriteRows = 4'd15;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_A    = 4'b0100,
    ST_B    = 4'b1000
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic [ByteW-1:0] pat_a;
    logic [ByteW-1:0] pat_b;
    logic             split;
    logic             skip;
    logic             last;
    logic [ByteW-1:0] wdata;
  } cmd_t;

endpackage

// ===== sv/sxf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sxf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sxf_front.sv =====
// Front end: decodes an input beat into a command with byte addresses and patterns.
module sxf_front (
  input  logic [1:0]   opcode_i,
  input  logic [5:0]   x_pos_i,
  input  logic [4:0]   y_pos_i,
  input  logic [3:0]   row_index_i,
  input  logic [7:0]   row_bits_i,
  input  logic         last_row_i,
  input  logic [7:0]   address_i,
  input  logic [7:0]   write_data_i,
  output sxf_pkg::cmd_t cmd_o
);
  import sxf_pkg::*;

  logic [5:0]  row_sum;
  logic [4:0]  row;
  logic [2:0]  col;
  logic [3:0]  col_b_sum;
  logic [2:0]  shift;
  logic [15:0] spread;

  assign row_sum   = {1'b0, y_pos_i} + {2'b00, row_index_i};
  assign row       = row_sum[4:0];
  assign col       = x_pos_i[5:3];
  assign col_b_sum = {1'b0, col} + 4'd1;
  assign shift     = x_pos_i[2:0];
  assign spread    = {row_bits_i, 8'h00} >> shift;

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op_e'(opcode_i);
    cmd_o.last   = last_row_i;
    cmd_o.wdata  = write_data_i;
    unique case (op_e'(opcode_i)) inside
      OP_DRAW: begin
        cmd_o.addr_a = {row, col};
        cmd_o.addr_b = {row, col_b_sum[2:0]};
        cmd_o.pat_a  = spread[15:8];
        cmd_o.pat_b  = spread[7:0];
        cmd_o.split  = (shift != 3'd0);
        cmd_o.skip   = (row_index_i >= MaxSpriteRows);
      end
      OP_READ, OP_WRITE: begin
        cmd_o.addr_a = address_i;
      end
      OP_CLEAR: begin
        cmd_o.skip = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/sxf_cmd_fifo.sv =====
// Short command queue between the front end and the draw engine.
module sxf_cmd_fifo #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sxf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sxf_pkg::cmd_t data_o
);
  import sxf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/sxf_back.sv =====
// Back end: read-modify-write sequencer over the screen RAM, collision and result register.
module sxf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  sxf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    read_data_o,
  output logic          collision_o
);
  import sxf_pkg::*;

  state_e                 state_q, state_d;
  cmd_t                   cur_q, cur_d;
  logic [ScreenBytes-1:0] valid_q, valid_d;
  logic                   rvld_q;
  logic                   acc_q, acc_d;
  logic                   out_vld_q, out_vld_d;
  logic [ByteW-1:0]       out_rd_q, out_rd_d;
  logic                   out_col_q, out_col_d;

  logic                   we;
  logic [AddrW-1:0]       waddr, raddr;
  logic [ByteW-1:0]       wdata, rdata, old;
  logic                   take, out_free, hit, total, finish;
  logic [ByteW-1:0]       fin_rd;
  logic                   fin_last;
  cmd_t                   cmd_sel;

  sxf_ram #(
    .Width (ByteW),
    .Depth (ScreenBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free  = !out_vld_q || pop;
  assign take      = (state_q == ST_IDLE) && !cmd_empty_i && out_free;
  assign cmd_pop_o = take;
  assign raddr     = (state_q == ST_IDLE) ? cmd_i.addr_a : cur_q.addr_b;
  assign old       = rdata & {ByteW{rvld_q}};
  assign cmd_sel   = take ? cmd_i : cur_q;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    valid_d  = valid_q;
    acc_d    = acc_q;
    we       = 1'b0;
    waddr    = cmd_sel.addr_a;
    wdata    = cmd_sel.wdata;
    hit      = 1'b0;
    finish   = 1'b0;
    fin_rd   = '0;
    fin_last = 1'b0;
    total    = acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cur_d = cmd_i;
          unique case (cmd_i.op)
            OP_DRAW: begin
              if (cmd_i.skip) begin
                finish   = 1'b1;
                fin_last = cmd_i.last;
              end else begin
                state_d = ST_A;
              end
            end
            OP_READ: begin
              state_d = ST_RD;
            end
            OP_WRITE: begin
              we                    = 1'b1;
              valid_d[cmd_i.addr_a] = 1'b1;
              finish                = 1'b1;
            end
            OP_CLEAR: begin
              valid_d = '0;
              finish  = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        finish  = 1'b1;
        fin_rd  = old;
        state_d = ST_IDLE;
      end
      ST_A: begin
        we                    = 1'b1;
        waddr                 = cur_q.addr_a;
        wdata                 = old ^ cur_q.pat_a;
        valid_d[cur_q.addr_a] = 1'b1;
        hit                   = |(old & cur_q.pat_a);
        total                 = acc_q | hit;
        if (cur_q.split) begin
          acc_d   = total;
          state_d = ST_B;
        end else begin
          finish   = 1'b1;
          fin_last = cur_q.last;
          state_d  = ST_IDLE;
        end
      end
      ST_B: begin
        we                    = 1'b1;
        waddr                 = cur_q.addr_b;
        wdata                 = old ^ cur_q.pat_b;
        valid_d[cur_q.addr_b] = 1'b1;
        hit                   = |(old & cur_q.pat_b);
        total                 = acc_q | hit;
        finish                = 1'b1;
        fin_last              = cur_q.last;
        state_d               = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish && cmd_sel.op == OP_DRAW) begin
      acc_d = fin_last ? 1'b0 : total;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_rd_d  = out_rd_q;
    out_col_d = out_col_q;
    if (finish) begin
      out_vld_d = 1'b1;
      out_rd_d  = fin_rd;
      out_col_d = fin_last && total;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      acc_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rvld_q    <= valid_q[raddr];
    out_rd_q  <= out_rd_d;
    out_col_q <= out_col_d;
  end

  assign empty       = !out_vld_q;
  assign read_data_o = out_rd_q;
  assign collision_o = out_col_q;

endmodule

// ===== sv/sprite_xor_framebuffer.sv =====
// Top level of the sprite XOR framebuffer.
// Steps: a write, clear or skipped row finishes when it is taken from the queue; a read
// passes through ST_RD, an aligned draw row through ST_A, a split draw row through ST_A and ST_B.
// No new item is taken until the last is through; the screen RAM has one read and one write port.
// The command queue decouples input beats from the engine; one result register holds output.
// Reset: asynchronous, active low; screen reads as all zero, collision sum cleared, queues empty.
module sprite_xor_framebuffer #(
  parameter int QueueDepth = sxf_pkg::CmdDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode_i,
  input  logic [5:0] x_pos_i,
  input  logic [4:0] y_pos_i,
  input  logic [3:0] row_index_i,
  input  logic [7:0] row_bits_i,
  input  logic       last_row_i,
  input  logic [7:0] address_i,
  input  logic [7:0] write_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_data_o,
  output logic       collision_o
);
  import sxf_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_empty, cmd_pop;

  sxf_front u_front (
    .opcode_i     (opcode_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .row_index_i  (row_index_i),
    .row_bits_i   (row_bits_i),
    .last_row_i   (last_row_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cmd_o        (cmd_in)
  );

  sxf_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  sxf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .read_data_o (read_data_o),
    .collision_o (collision_o)
  );

endmodule

// ===== sv/sxf_checker.sv =====
// Port-level checks for the sprite XOR framebuffer, bound to the top level.
module sxf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] read_data_o,
  input logic       collision_o
);

  a_rd_col_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && collision_o) |-> (read_data_o == 8'd0))
    else $error("collision shown together with read data");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(read_data_o) && $stable(collision_o)))
    else $error("stalled result changed");

endmodule

bind sprite_xor_framebuffer sxf_checker u_sxf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .read_data_o (read_data_o),
  .collision_o (collision_o)
);
